// ----- hdl/dss_pkg.sv -----
// Shared types, codes and constants of the drive sequencer with soft-start ramp.
// No dependencies; every other file of the block imports this package.
package dss_pkg;

    // Parameter defaults
    localparam int DUTY_BITS_DEF    = 8;
    localparam int TIMER_BITS_DEF   = 16;
    localparam int CENTER_DEG_DEF   = 90;
    localparam int STEER_OFFSET_DEF = 10;

    localparam int ANGLE_MAX   = 180;
    localparam int ECHO_SCALE  = 17;    // echo microseconds to centimetres, times 1000
    localparam int OBST_SCALE  = 1000;
    localparam int PCT_DIV     = 100;
    localparam int PCT_ENTRIES = 128;
    localparam int RECIP_EXTRA = 7;     // reciprocal shift is DUTY_BITS plus this

    localparam int OBST_THR_BITS = 19;
    localparam int ECHO_X_BITS   = 20;

    // Configuration reset values
    localparam int RST_MAX_SPEED = 180;
    localparam int RST_MIN_SPEED = 30;
    localparam int RST_STEP      = 10;
    localparam int RST_RAMP_MS   = 50;
    localparam int RST_SERVO_MS  = 500;
    localparam int RST_STOP_MS   = 300;
    localparam int RST_OBST_CM   = 5;
    localparam int RST_INNER_PCT = 60;

    typedef enum logic [2:0] {
        CFG_MAX_SPEED = 3'd0,
        CFG_MIN_SPEED = 3'd1,
        CFG_STEP      = 3'd2,
        CFG_RAMP_MS   = 3'd3,
        CFG_SERVO_MS  = 3'd4,
        CFG_STOP_MS   = 3'd5,
        CFG_OBST_CM   = 3'd6,
        CFG_INNER_PCT = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MO_STOP  = 3'd0,
        MO_FWD   = 3'd1,
        MO_BACK  = 3'd2,
        MO_LEFT  = 3'd3,
        MO_RIGHT = 3'd4
    } t_motion;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_SERVO    = 5'b00010,
        PH_RUN      = 5'b00100,
        PH_STOPPING = 5'b01000,
        PH_RETURN   = 5'b10000
    } t_phase;

    // Phase codes as reported on the result
    localparam logic [2:0] PHC_IDLE     = 3'd0;
    localparam logic [2:0] PHC_SERVO    = 3'd1;
    localparam logic [2:0] PHC_RUN      = 3'd2;
    localparam logic [2:0] PHC_STOPPING = 3'd3;
    localparam logic [2:0] PHC_RETURN   = 3'd4;

    // Command status codes
    localparam logic [2:0] ST_NONE      = 3'd0;
    localparam logic [2:0] ST_ACCEPTED  = 3'd1;
    localparam logic [2:0] ST_BLOCKED   = 3'd2;
    localparam logic [2:0] ST_BUSY      = 3'd3;
    localparam logic [2:0] ST_SPEED_OFF = 3'd4;
    localparam logic [2:0] ST_UNKNOWN   = 3'd5;

    // Command characters
    localparam logic [7:0] CHR_F      = 8'h46;
    localparam logic [7:0] CHR_B      = 8'h42;
    localparam logic [7:0] CHR_L      = 8'h4C;
    localparam logic [7:0] CHR_R      = 8'h52;
    localparam logic [7:0] CHR_S      = 8'h53;
    localparam logic [7:0] CHR_LOW_A  = 8'h61;
    localparam logic [7:0] CHR_LOW_Z  = 8'h7A;
    localparam logic [7:0] CHR_ZERO   = 8'h30;
    localparam logic [7:0] CHR_COLON  = 8'h3A;
    localparam logic [7:0] CASE_SHIFT = 8'd32;

    typedef struct packed {
        logic [7:0]               max_speed;
        logic [7:0]               min_speed;
        logic [6:0]               speed_step;
        logic [15:0]              ramp_ms;
        logic [15:0]              servo_ms;
        logic [15:0]              stop_ms;
        logic [OBST_THR_BITS-1:0] obst_thr;   // obstacle_cm * 1000
    } t_cfg;

    typedef struct packed {
        logic        cmd_valid;
        logic [7:0]  cmd_byte;
        logic        range_valid;
        logic [14:0] echo_us;
    } t_req;

    typedef struct packed {
        logic [7:0] right_fwd_duty;
        logic [7:0] right_rev_duty;
        logic [7:0] left_fwd_duty;
        logic [7:0] left_rev_duty;
        logic [7:0] steer_angle;
        logic [2:0] seq_phase;
        logic [2:0] motion_now;
        logic       obstacle_flag;
        logic [2:0] cmd_status;
        logic [7:0] ramp_speed;
    } t_res;

    typedef logic [31:0] t_recip_tbl [PCT_ENTRIES];

    // Reciprocal factors for floor(x * pct / 100) as (x * k) >> shift,
    // exact for x below 2^(shift - RECIP_EXTRA). Built at elaboration.
    function automatic t_recip_tbl recip_table(input int shift);
        t_recip_tbl tbl;
        for (int i = 0; i < PCT_ENTRIES; i++) begin
            tbl[i] = 32'(((longint'(i) << shift) / PCT_DIV) + 1);
        end
        return tbl;
    endfunction

endpackage

// ----- hdl/dss_req_if.sv -----
// Request channel of the drive sequencer: valid, ready and one tick's input fields.
// Depends on dss_pkg for the payload type.
interface dss_req_if;
    import dss_pkg::*;

    logic valid;
    logic ready;
    t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/dss_res_if.sv -----
// Result channel of the drive sequencer: valid, ready and one tick's result fields.
// Depends on dss_pkg for the payload type.
interface dss_res_if;
    import dss_pkg::*;

    logic valid;
    logic ready;
    t_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/dss_cfg_regs.sv -----
// Configuration registers of the drive sequencer, with the derived obstacle
// threshold and inner-wheel reciprocal factor. Depends on dss_pkg.
module dss_cfg_regs #(
    parameter int DUTY_BITS = dss_pkg::DUTY_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [2:0]              i_cfg_idx,
    input  logic [15:0]             i_cfg_data,
    output dss_pkg::t_cfg           o_cfg,
    output logic [DUTY_BITS+dss_pkg::RECIP_EXTRA:0] o_inner_k
);
    import dss_pkg::*;

    localparam int         SHIFT    = DUTY_BITS + RECIP_EXTRA;
    localparam int         KW       = SHIFT + 1;
    localparam t_recip_tbl RECIP    = recip_table(SHIFT);

    t_cfg          r_cfg;
    logic [KW-1:0] r_inner_k;
    t_cfg_idx      idx;

    assign idx = t_cfg_idx'(i_cfg_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_speed  <= 8'(RST_MAX_SPEED);
            r_cfg.min_speed  <= 8'(RST_MIN_SPEED);
            r_cfg.speed_step <= 7'(RST_STEP);
            r_cfg.ramp_ms    <= 16'(RST_RAMP_MS);
            r_cfg.servo_ms   <= 16'(RST_SERVO_MS);
            r_cfg.stop_ms    <= 16'(RST_STOP_MS);
            r_cfg.obst_thr   <= OBST_THR_BITS'(RST_OBST_CM * OBST_SCALE);
            r_inner_k        <= RECIP[RST_INNER_PCT][KW-1:0];
        end else if (i_cfg_we) begin
            case (idx)
                CFG_MAX_SPEED: r_cfg.max_speed  <= i_cfg_data[7:0];
                CFG_MIN_SPEED: r_cfg.min_speed  <= i_cfg_data[7:0];
                CFG_STEP:      r_cfg.speed_step <= i_cfg_data[6:0];
                CFG_RAMP_MS:   r_cfg.ramp_ms    <= i_cfg_data;
                CFG_SERVO_MS:  r_cfg.servo_ms   <= i_cfg_data;
                CFG_STOP_MS:   r_cfg.stop_ms    <= i_cfg_data;
                // scale once here so the tick path only compares
                CFG_OBST_CM:   r_cfg.obst_thr   <= OBST_THR_BITS'(i_cfg_data[8:0])
                                                   * OBST_THR_BITS'(OBST_SCALE);
                CFG_INNER_PCT: r_inner_k        <= RECIP[i_cfg_data[6:0]][KW-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg     = r_cfg;
    assign o_inner_k = r_inner_k;
endmodule

// ----- hdl/dss_core.sv -----
// Sequencer state and the per-tick update: obstacle latch, command decode,
// phase sequencer, soft-start ramp and servo. Depends on dss_pkg.
module dss_core #(
    parameter int DUTY_BITS        = dss_pkg::DUTY_BITS_DEF,
    parameter int TIMER_BITS       = dss_pkg::TIMER_BITS_DEF,
    parameter int CENTER_DEG       = dss_pkg::CENTER_DEG_DEF,
    parameter int STEER_OFFSET_DEG = dss_pkg::STEER_OFFSET_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  dss_pkg::t_req           i_req,
    input  dss_pkg::t_cfg           i_cfg,
    input  logic [DUTY_BITS+dss_pkg::RECIP_EXTRA:0] i_inner_k,
    output dss_pkg::t_res           o_res
);
    import dss_pkg::*;

    localparam int SHIFT    = DUTY_BITS + RECIP_EXTRA;
    localparam int KW       = SHIFT + 1;
    localparam int PW       = DUTY_BITS + KW;
    localparam int WW       = (DUTY_BITS > 8 ? DUTY_BITS : 8) + 2;
    localparam int CW       = (TIMER_BITS > 16 ? TIMER_BITS : 16);
    localparam int DUTY_MAX = (1 << DUTY_BITS) - 1;

    localparam logic [7:0] ANG_LEFT   = 8'((CENTER_DEG + STEER_OFFSET_DEG > ANGLE_MAX)
                                           ? ANGLE_MAX : CENTER_DEG + STEER_OFFSET_DEG);
    localparam logic [7:0] ANG_RIGHT  = 8'((CENTER_DEG < STEER_OFFSET_DEG)
                                           ? 0 : CENTER_DEG - STEER_OFFSET_DEG);
    localparam logic [7:0] ANG_CENTER = 8'((CENTER_DEG > ANGLE_MAX) ? ANGLE_MAX : CENTER_DEG);

    localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};
    localparam logic [WW-1:0]         DMAX = WW'(DUTY_MAX);

    logic [DUTY_BITS-1:0]  r_speed,   n_speed;
    t_motion               r_cur,     n_cur;
    t_motion               r_goal,    n_goal;
    t_motion               r_pend,    n_pend;
    t_phase                r_phase,   n_phase;
    logic                  r_latch,   n_latch;
    logic [TIMER_BITS-1:0] r_ramp_el, n_ramp_el;
    logic [TIMER_BITS-1:0] r_ph_el,   n_ph_el;
    logic [7:0]            r_servo,   n_servo;
    logic [DUTY_BITS-1:0]  r_duty [4];
    logic [DUTY_BITS-1:0]  n_duty [4];
    logic [2:0]            status;
    logic [2:0]            phase_code;

    always_comb begin
        logic [ECHO_X_BITS-1:0] echo_x;
        logic                   hit;
        logic [7:0]             c;
        logic [WW-1:0]          sp_w;
        logic [WW-1:0]          ceil_w;
        logic [WW-1:0]          dec_w;
        logic [WW-1:0]          min_w;
        logic [PW-1:0]          prod;
        logic [DUTY_BITS:0]     q;
        logic [DUTY_BITS-1:0]   inner;

        n_speed   = r_speed;
        n_cur     = r_cur;
        n_goal    = r_goal;
        n_pend    = r_pend;
        n_phase   = r_phase;
        n_latch   = r_latch;
        n_servo   = r_servo;
        n_duty    = r_duty;
        status    = ST_NONE;
        n_ramp_el = (r_ramp_el == TMAX) ? r_ramp_el : r_ramp_el + 1'b1;
        n_ph_el   = (r_ph_el == TMAX) ? r_ph_el : r_ph_el + 1'b1;

        // obstacle latch
        echo_x = ECHO_X_BITS'(i_req.echo_us) * ECHO_X_BITS'(ECHO_SCALE);
        hit    = (i_req.echo_us != '0) && (echo_x <= ECHO_X_BITS'(i_cfg.obst_thr));
        if (i_req.range_valid) begin
            if (hit) begin
                if (!n_latch) begin
                    n_latch = 1'b1;
                    if (n_goal inside {MO_FWD, MO_LEFT, MO_RIGHT}) begin
                        if (n_phase == PH_RUN && (n_cur inside {MO_LEFT, MO_RIGHT})) begin
                            n_phase = PH_STOPPING;
                            n_ph_el = '0;
                        end else begin
                            n_phase = PH_IDLE;
                        end
                        n_goal = MO_STOP;
                    end
                end
            end else begin
                n_latch = 1'b0;
            end
        end

        // command decode, either case
        c = i_req.cmd_byte;
        if (c inside {[CHR_LOW_A:CHR_LOW_Z]}) begin
            c = c - CASE_SHIFT;
        end
        if (i_req.cmd_valid) begin
            case (c)
                CHR_S: begin
                    if (n_phase == PH_RUN && (n_cur inside {MO_LEFT, MO_RIGHT})) begin
                        n_phase = PH_STOPPING;
                        n_ph_el = '0;
                    end else begin
                        n_phase = PH_IDLE;
                    end
                    n_goal = MO_STOP;
                    status = ST_ACCEPTED;
                end
                CHR_F: begin
                    if (n_latch) begin
                        status = ST_BLOCKED;
                    end else begin
                        n_goal = MO_FWD;
                        status = ST_ACCEPTED;
                    end
                end
                CHR_B: begin
                    n_goal = MO_BACK;
                    status = ST_ACCEPTED;
                end
                CHR_L, CHR_R: begin
                    if (n_latch) begin
                        status = ST_BLOCKED;
                    end else if (n_phase != PH_IDLE) begin
                        status = ST_BUSY;
                    end else begin
                        n_pend  = (c == CHR_L) ? MO_LEFT : MO_RIGHT;
                        n_servo = (c == CHR_L) ? ANG_LEFT : ANG_RIGHT;
                        n_phase = PH_SERVO;
                        n_ph_el = '0;
                        status  = ST_ACCEPTED;
                    end
                end
                default: begin
                    if (c inside {[CHR_ZERO:CHR_COLON]}) begin
                        status = ST_SPEED_OFF;
                    end else begin
                        status = ST_UNKNOWN;
                    end
                end
            endcase
        end

        // phase sequencer
        case (n_phase)
            PH_SERVO: begin
                if (CW'(n_ph_el) >= CW'(i_cfg.servo_ms)) begin
                    n_phase = PH_RUN;
                    n_goal  = n_pend;
                end
            end
            PH_STOPPING: begin
                if (n_cur == MO_STOP && CW'(n_ph_el) >= CW'(i_cfg.stop_ms)) begin
                    n_phase = PH_RETURN;
                    n_ph_el = '0;
                    n_servo = ANG_CENTER;
                end
            end
            PH_RETURN: begin
                if (CW'(n_ph_el) >= CW'(i_cfg.servo_ms)) begin
                    n_phase = PH_IDLE;
                end
            end
            default: ;
        endcase

        // soft-start ramp
        ceil_w = (WW'(i_cfg.max_speed) > DMAX) ? DMAX : WW'(i_cfg.max_speed);
        min_w  = (WW'(i_cfg.min_speed) > DMAX) ? DMAX : WW'(i_cfg.min_speed);
        dec_w  = WW'({i_cfg.speed_step, 1'b0});
        sp_w   = WW'(n_speed);
        if (CW'(n_ramp_el) >= CW'(i_cfg.ramp_ms)) begin
            n_ramp_el = '0;
            // the slot is used up even while the servo is moving
            if (n_phase inside {PH_IDLE, PH_RUN, PH_STOPPING}) begin
                if (n_goal == MO_STOP) begin
                    if (sp_w != '0) begin
                        sp_w = (sp_w > dec_w) ? sp_w - dec_w : '0;
                        if (sp_w == '0) begin
                            n_cur = MO_STOP;
                            for (int i = 0; i < 4; i++) begin
                                n_duty[i] = '0;
                            end
                        end
                    end
                end else if (n_cur != n_goal) begin
                    sp_w  = min_w;
                    n_cur = n_goal;
                    if (n_goal == MO_BACK) begin
                        n_duty[0] = '0;
                        n_duty[2] = '0;
                    end else begin
                        n_duty[1] = '0;
                        n_duty[3] = '0;
                    end
                end else if (sp_w < ceil_w) begin
                    sp_w = sp_w + WW'(i_cfg.speed_step);
                    if (sp_w > ceil_w) begin
                        sp_w = ceil_w;
                    end
                end
                n_speed = sp_w[DUTY_BITS-1:0];

                prod  = PW'(n_speed) * PW'(i_inner_k);
                q     = prod[PW-1:SHIFT];
                inner = q[DUTY_BITS] ? {DUTY_BITS{1'b1}} : q[DUTY_BITS-1:0];
                if (n_speed != '0) begin
                    case (n_cur)
                        MO_FWD: begin
                            n_duty[0] = n_speed;
                            n_duty[2] = n_speed;
                        end
                        MO_BACK: begin
                            n_duty[1] = n_speed;
                            n_duty[3] = n_speed;
                        end
                        MO_LEFT: begin
                            n_duty[0] = n_speed;
                            n_duty[2] = inner;
                        end
                        MO_RIGHT: begin
                            n_duty[0] = inner;
                            n_duty[2] = n_speed;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_comb begin
        case (n_phase)
            PH_IDLE:     phase_code = PHC_IDLE;
            PH_SERVO:    phase_code = PHC_SERVO;
            PH_RUN:      phase_code = PHC_RUN;
            PH_STOPPING: phase_code = PHC_STOPPING;
            PH_RETURN:   phase_code = PHC_RETURN;
            default:     phase_code = PHC_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed   <= '0;
            r_cur     <= MO_STOP;
            r_goal    <= MO_STOP;
            r_pend    <= MO_STOP;
            r_phase   <= PH_IDLE;
            r_latch   <= 1'b0;
            r_ramp_el <= '0;
            r_ph_el   <= '0;
            r_servo   <= ANG_CENTER;
            for (int i = 0; i < 4; i++) begin
                r_duty[i] <= '0;
            end
        end else if (i_step) begin
            r_speed   <= n_speed;
            r_cur     <= n_cur;
            r_goal    <= n_goal;
            r_pend    <= n_pend;
            r_phase   <= n_phase;
            r_latch   <= n_latch;
            r_ramp_el <= n_ramp_el;
            r_ph_el   <= n_ph_el;
            r_servo   <= n_servo;
            r_duty    <= n_duty;
        end
    end

    assign o_res.right_fwd_duty = 8'(n_duty[0]);
    assign o_res.right_rev_duty = 8'(n_duty[1]);
    assign o_res.left_fwd_duty  = 8'(n_duty[2]);
    assign o_res.left_rev_duty  = 8'(n_duty[3]);
    assign o_res.steer_angle    = n_servo;
    assign o_res.seq_phase      = phase_code;
    assign o_res.motion_now     = n_cur;
    assign o_res.obstacle_flag  = n_latch;
    assign o_res.cmd_status     = status;
    assign o_res.ramp_speed     = 8'(n_speed);
endmodule

// ----- hdl/drive_sequencer_soft_start_unit.sv -----
// Top level of the drive sequencer with soft-start ramp: input register,
// sequencer core, result register and configuration registers.
// Depends on dss_pkg, dss_req_if, dss_res_if, dss_cfg_regs and dss_core.
//
//  channel   direction  carries
//  i_req     in         one millisecond tick: command byte and echo time
//  o_res     out        four duties, servo angle, phase, motion, flags, speed
//  i_cfg_*   in         register writes, index 0..7, no read-back
//
// One tick per cycle sustained while results are taken; an accepted request is
// captured into the input register, and its core update goes into the result
// register. The core logic between the two registers, one small multiply for
// the inner wheel, sets the clock. Reset is synchronous and active low and
// clears the sequencer state, valid flags and configuration registers to their
// defaults, but not the payload registers. A stalled result holds both
// registers; a new tick is still taken while the input register is free.
module drive_sequencer_soft_start_unit #(
    parameter int DUTY_BITS        = dss_pkg::DUTY_BITS_DEF,
    parameter int TIMER_BITS       = dss_pkg::TIMER_BITS_DEF,
    parameter int CENTER_DEG       = dss_pkg::CENTER_DEG_DEF,
    parameter int STEER_OFFSET_DEG = dss_pkg::STEER_OFFSET_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dss_req_if.sink     i_req,
    dss_res_if.source   o_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import dss_pkg::*;

    localparam int KW = DUTY_BITS + RECIP_EXTRA + 1;

    logic          r_in_valid;
    t_req          r_in_data;
    logic          r_out_valid;
    t_res          r_out_data;
    logic          advance;
    logic          step;
    t_cfg          cfg;
    logic [KW-1:0] inner_k;
    t_res          core_res;

    assign advance     = !r_out_valid || o_res.ready;
    assign step        = r_in_valid && advance;
    assign i_req.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload registers: capture only, no reset
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_data <= i_req.data;
        end
        if (step) begin
            r_out_data <= core_res;
        end
    end

    dss_cfg_regs #(
        .DUTY_BITS (DUTY_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg),
        .o_inner_k  (inner_k)
    );

    dss_core #(
        .DUTY_BITS        (DUTY_BITS),
        .TIMER_BITS       (TIMER_BITS),
        .CENTER_DEG       (CENTER_DEG),
        .STEER_OFFSET_DEG (STEER_OFFSET_DEG)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_req     (r_in_data),
        .i_cfg     (cfg),
        .i_inner_k (inner_k),
        .o_res     (core_res)
    );

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out_data;
endmodule

// ----- dv/dss_tick_checker.sv -----
// Watches the request, result and register-write traffic of the drive sequencer,
// predicts each tick's result and compares it field by field. Depends on dss_pkg,
// dss_req_if and dss_res_if.
`timescale 1ns / 1ps

module dss_tick_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dss_req_if          i_req,
    dss_res_if          i_res,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_outstanding
);
    import dss_pkg::*;

    localparam int DUTY_MAX = (1 << DUTY_BITS_DEF) - 1;
    localparam logic [7:0] ANG_CENTRE = 8'(CENTER_DEG_DEF);
    localparam logic [7:0] ANG_LEFT   = 8'((CENTER_DEG_DEF + STEER_OFFSET_DEF > ANGLE_MAX) ?
                                           ANGLE_MAX : CENTER_DEG_DEF + STEER_OFFSET_DEF);
    localparam logic [7:0] ANG_RIGHT  = 8'((CENTER_DEG_DEF - STEER_OFFSET_DEF < 0) ?
                                           0 : CENTER_DEG_DEF - STEER_OFFSET_DEF);

    // register copies
    logic [7:0]  cfg_max, cfg_min;
    logic [6:0]  cfg_step, cfg_inner;
    logic [15:0] cfg_ramp, cfg_servo, cfg_stop;
    logic [8:0]  cfg_obst;

    // sequencer state
    logic [7:0]                spd;
    t_motion                   mo_cur, mo_goal, mo_pend;
    logic [2:0]                phase;
    logic                      obst;
    logic [TIMER_BITS_DEF-1:0] ramp_ms, phase_ms;
    logic [7:0]                angle;
    logic [7:0]                duty [4];

    t_res expected_ticks [$];
    int   mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic void clear_duty(t_motion m);
        case (m)
            MO_BACK: begin
                duty[0] = '0;
                duty[2] = '0;
            end
            MO_STOP: begin
                for (int i = 0; i < 4; i++) duty[i] = '0;
            end
            default: begin
                duty[1] = '0;
                duty[3] = '0;
            end
        endcase
    endfunction

    function automatic void halt_drive();
        if (phase == PHC_RUN && (mo_cur == MO_LEFT || mo_cur == MO_RIGHT)) begin
            phase    = PHC_STOPPING;
            phase_ms = '0;
        end else begin
            phase = PHC_IDLE;
        end
        mo_goal = MO_STOP;
    endfunction

    function automatic logic [2:0] start_turn(t_motion dir);
        if (phase != PHC_IDLE) return ST_BUSY;
        mo_pend  = dir;
        phase    = PHC_SERVO;
        phase_ms = '0;
        angle    = (dir == MO_LEFT) ? ANG_LEFT : ANG_RIGHT;
        return ST_ACCEPTED;
    endfunction

    function automatic logic [2:0] take_command(logic [7:0] c);
        logic [7:0] u;
        u = (c >= CHR_LOW_A && c <= CHR_LOW_Z) ? c - CASE_SHIFT : c;
        case (u)
            CHR_S: begin
                halt_drive();
                return ST_ACCEPTED;
            end
            CHR_F: begin
                if (obst) return ST_BLOCKED;
                mo_goal = MO_FWD;
                return ST_ACCEPTED;
            end
            CHR_B: begin
                mo_goal = MO_BACK;
                return ST_ACCEPTED;
            end
            CHR_L: begin
                if (obst) return ST_BLOCKED;
                return start_turn(MO_LEFT);
            end
            CHR_R: begin
                if (obst) return ST_BLOCKED;
                return start_turn(MO_RIGHT);
            end
            default: return (u >= CHR_ZERO && u <= CHR_COLON) ? ST_SPEED_OFF : ST_UNKNOWN;
        endcase
    endfunction

    function automatic void ramp_step();
        int nxt;
        int inner;
        // the slot is spent even when the phase takes no ramp
        if (phase != PHC_IDLE && phase != PHC_RUN && phase != PHC_STOPPING) return;
        if (mo_goal == MO_STOP) begin
            if (spd > 0) begin
                nxt = int'(spd) - 2 * int'(cfg_step);
                spd = (nxt > 0) ? 8'(nxt) : '0;
                if (spd == 0) begin
                    mo_cur = MO_STOP;
                    clear_duty(MO_STOP);
                end
            end
        end else if (mo_cur != mo_goal) begin
            spd    = cfg_min;
            mo_cur = mo_goal;
            clear_duty(mo_cur);
        end else if (spd < cfg_max) begin
            nxt = int'(spd) + int'(cfg_step);
            spd = (nxt > int'(cfg_max)) ? cfg_max : 8'(nxt);
        end
        if (spd == 0 || mo_cur == MO_STOP) return;
        inner = int'(spd) * int'(cfg_inner) / PCT_DIV;
        if (inner > DUTY_MAX) inner = DUTY_MAX;
        case (mo_cur)
            MO_FWD: begin
                duty[0] = spd;
                duty[2] = spd;
            end
            MO_BACK: begin
                duty[1] = spd;
                duty[3] = spd;
            end
            MO_LEFT: begin
                duty[0] = spd;
                duty[2] = 8'(inner);
            end
            MO_RIGHT: begin
                duty[0] = 8'(inner);
                duty[2] = spd;
            end
            default: ;
        endcase
    endfunction

    function automatic t_res drive_tick(t_req r);
        logic [2:0] status;
        t_res       o;
        status = ST_NONE;
        if (!(&ramp_ms)) ramp_ms++;
        if (!(&phase_ms)) phase_ms++;

        if (r.range_valid) begin
            if (r.echo_us != 0 &&
                ECHO_SCALE * int'(r.echo_us) <= OBST_SCALE * int'(cfg_obst)) begin
                if (!obst) begin
                    obst = 1'b1;
                    if (mo_goal == MO_FWD || mo_goal == MO_LEFT || mo_goal == MO_RIGHT)
                        halt_drive();
                end
            end else begin
                obst = 1'b0;
            end
        end

        if (r.cmd_valid) status = take_command(r.cmd_byte);

        case (phase)
            PHC_SERVO: begin
                if (phase_ms >= cfg_servo) begin
                    phase   = PHC_RUN;
                    mo_goal = mo_pend;
                end
            end
            PHC_STOPPING: begin
                if (mo_cur == MO_STOP && phase_ms >= cfg_stop) begin
                    phase    = PHC_RETURN;
                    phase_ms = '0;
                    angle    = ANG_CENTRE;
                end
            end
            PHC_RETURN: begin
                if (phase_ms >= cfg_servo) phase = PHC_IDLE;
            end
            default: ;
        endcase

        if (ramp_ms >= cfg_ramp) begin
            ramp_ms = '0;
            ramp_step();
        end

        o.right_fwd_duty = duty[0];
        o.right_rev_duty = duty[1];
        o.left_fwd_duty  = duty[2];
        o.left_rev_duty  = duty[3];
        o.steer_angle    = angle;
        o.seq_phase      = phase;
        o.motion_now     = mo_cur;
        o.obstacle_flag  = obst;
        o.cmd_status     = status;
        o.ramp_speed     = spd;
        return o;
    endfunction

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        if (!i_rst_n) begin
            cfg_max   = 8'(RST_MAX_SPEED);
            cfg_min   = 8'(RST_MIN_SPEED);
            cfg_step  = 7'(RST_STEP);
            cfg_ramp  = 16'(RST_RAMP_MS);
            cfg_servo = 16'(RST_SERVO_MS);
            cfg_stop  = 16'(RST_STOP_MS);
            cfg_obst  = 9'(RST_OBST_CM);
            cfg_inner = 7'(RST_INNER_PCT);
            spd       = '0;
            mo_cur    = MO_STOP;
            mo_goal   = MO_STOP;
            mo_pend   = MO_STOP;
            phase     = PHC_IDLE;
            obst      = 1'b0;
            ramp_ms   = '0;
            phase_ms  = '0;
            angle     = ANG_CENTRE;
            clear_duty(MO_STOP);
            expected_ticks.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_SPEED: cfg_max   = i_cfg_data[7:0];
                    CFG_MIN_SPEED: cfg_min   = i_cfg_data[7:0];
                    CFG_STEP:      cfg_step  = i_cfg_data[6:0];
                    CFG_RAMP_MS:   cfg_ramp  = i_cfg_data;
                    CFG_SERVO_MS:  cfg_servo = i_cfg_data;
                    CFG_STOP_MS:   cfg_stop  = i_cfg_data;
                    CFG_OBST_CM:   cfg_obst  = i_cfg_data[8:0];
                    CFG_INNER_PCT: cfg_inner = i_cfg_data[6:0];
                    default: ;
                endcase
            end
            // match the result before queueing this edge's request
            if (i_res.valid && i_res.ready) begin
                got = i_res.data;
                if (expected_ticks.size() == 0) begin
                    $error("result accepted with no request outstanding");
                    mismatches++;
                end else begin
                    want = expected_ticks.pop_front();
                    check_field("right_fwd_duty", want.right_fwd_duty, got.right_fwd_duty);
                    check_field("right_rev_duty", want.right_rev_duty, got.right_rev_duty);
                    check_field("left_fwd_duty", want.left_fwd_duty, got.left_fwd_duty);
                    check_field("left_rev_duty", want.left_rev_duty, got.left_rev_duty);
                    check_field("steer_angle", want.steer_angle, got.steer_angle);
                    check_field("seq_phase", 8'(want.seq_phase), 8'(got.seq_phase));
                    check_field("motion_now", 8'(want.motion_now), 8'(got.motion_now));
                    check_field("obstacle_flag", 8'(want.obstacle_flag), 8'(got.obstacle_flag));
                    check_field("cmd_status", 8'(want.cmd_status), 8'(got.cmd_status));
                    check_field("ramp_speed", want.ramp_speed, got.ramp_speed);
                end
            end
            if (i_req.valid && i_req.ready) expected_ticks.push_back(drive_tick(i_req.data));
        end
        o_outstanding <= expected_ticks.size();
    end

endmodule

// ----- dv/tb.sv -----
// Testbench top of the drive sequencer: clock, reset, register writes, tick requests
// and result back-pressure, with the checker beside the block giving the verdict.
// Depends on dss_pkg, dss_req_if, dss_res_if, dss_tick_checker and the block itself.
`timescale 1ns / 1ps

module tb;
    import dss_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RAND_TICKS     = 62;
    localparam int RAND_SETTINGS  = 6;
    localparam int LONG_TICKS     = 24;
    localparam int MAX_GAP        = 18;

    typedef struct packed {
        logic [7:0]  max_speed;
        logic [7:0]  min_speed;
        logic [6:0]  speed_step;
        logic [15:0] ramp_ms;
        logic [15:0] servo_ms;
        logic [15:0] stop_ms;
        logic [8:0]  obst_cm;
        logic [6:0]  inner_pct;
    } t_setting;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;

    dss_req_if req_ch ();
    dss_res_if res_ch ();

    int fail_count;
    int outstanding;
    int stall_cycles = 0;
    int ticks_sent = 0;
    int settings_loaded = 0;
    bit hurry_src, hurry_snk, hold_fast;

    drive_sequencer_soft_start_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_res      (res_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    dss_tick_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_ch),
        .i_res         (res_ch),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // abort when nothing moves on either channel for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // result side: stall a random number of cycles before taking each result, none while hurried
    initial begin : result_sink
        int stall;
        res_ch.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = (hurry_snk || hold_fast) ? 0 : $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 31) == 0) hurry_snk = !hurry_snk;
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
        end
    end

    function automatic t_req make_tick(logic cv, logic [7:0] c, logic rv, logic [14:0] e);
        t_req r;
        r.cmd_valid   = cv;
        r.cmd_byte    = c;
        r.range_valid = rv;
        r.echo_us     = e;
        return r;
    endfunction

    // mostly drive commands in either case, some speed digits and stray bytes;
    // echo times cluster round the obstacle threshold
    function automatic t_req rand_tick(logic [8:0] thr_cm);
        t_req r;
        int   pick;
        int   near_us;
        r.cmd_valid = ($urandom_range(0, 99) < 18);
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
            case ($urandom_range(0, 4))
                0: r.cmd_byte = CHR_F;
                1: r.cmd_byte = CHR_B;
                2: r.cmd_byte = CHR_L;
                3: r.cmd_byte = CHR_R;
                default: r.cmd_byte = CHR_S;
            endcase
            if ($urandom_range(0, 1)) r.cmd_byte = r.cmd_byte | CASE_SHIFT;
        end else if (pick < 85) begin
            r.cmd_byte = 8'($urandom_range(CHR_ZERO, CHR_COLON));
        end else begin
            r.cmd_byte = 8'($urandom);
        end
        r.range_valid = ($urandom_range(0, 99) < 8);
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            near_us = int'(thr_cm) * OBST_SCALE / ECHO_SCALE + int'($urandom_range(0, 2)) - 1;
            if (near_us < 0) near_us = 0;
            if (near_us > 32767) near_us = 32767;
            r.echo_us = 15'(near_us);
        end else if (pick < 55) begin
            r.echo_us = '0;
        end else begin
            r.echo_us = 15'($urandom_range(0, 30000));
        end
        return r;
    endfunction

    task automatic send_tick(t_req r);
        int gap;
        gap = (hurry_src || hold_fast) ? 0 : $urandom_range(0, MAX_GAP);
        if ($urandom_range(0, 31) == 0) hurry_src = !hurry_src;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.data  <= r;
        req_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);
        ticks_sent++;
    endtask

    task automatic send_empty(int n);
        repeat (n) send_tick(make_tick(1'b0, 8'h00, 1'b0, 15'h0000));
    endtask

    // hold off until every result of the requests so far is in
    task automatic drain();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic put_reg(t_cfg_idx idx, logic [15:0] val);
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic load_setting(t_setting s);
        i_cfg_we <= 1'b1;
        put_reg(CFG_MAX_SPEED, 16'(s.max_speed));
        put_reg(CFG_MIN_SPEED, 16'(s.min_speed));
        put_reg(CFG_STEP, 16'(s.speed_step));
        put_reg(CFG_RAMP_MS, s.ramp_ms);
        put_reg(CFG_SERVO_MS, s.servo_ms);
        put_reg(CFG_STOP_MS, s.stop_ms);
        put_reg(CFG_OBST_CM, 16'(s.obst_cm));
        put_reg(CFG_INNER_PCT, 16'(s.inner_pct));
        i_cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    initial begin : stimulus
        t_setting plan [8];
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= CFG_MAX_SPEED;
        i_cfg_data   <= '0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;

        //            max     min     step    ramp       servo      stop       obst    inner
        plan[0] = '{8'd200, 8'd30,  7'd20,  16'd2,     16'd3,     16'd4,     9'd50,  7'd60};
        plan[1] = '{8'd255, 8'd255, 7'd127, 16'd1,     16'd1,     16'd1,     9'd511, 7'd127};
        plan[2] = '{8'd0,   8'd0,   7'd0,   16'd0,     16'd0,     16'd0,     9'd0,   7'd0};
        plan[3] = '{8'd100, 8'd150, 7'd7,   16'd3,     16'd2,     16'd6,     9'd400, 7'd100};
        plan[4] = '{8'd255, 8'd1,   7'd1,   16'd1,     16'd5,     16'd0,     9'd10,  7'd33};
        plan[5] = '{8'd60,  8'd0,   7'd50,  16'd0,     16'd1,     16'd2,     9'd200, 7'd99};
        plan[6] = '{8'd200, 8'd30,  7'd127, 16'd0,     16'd0,     16'd0,     9'd0,   7'd60};
        plan[7] = '{8'd180, 8'd30,  7'd10,  16'd65535, 16'd65535, 16'd65535, 9'd5,   7'd60};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: ignored fields, obstacle blocking forward, widest echo
        send_tick(make_tick(1'b0, 8'hFF, 1'b0, 15'h7FFF));
        send_tick(make_tick(1'b1, CHR_F, 1'b1, 15'd100));
        send_tick(make_tick(1'b0, 8'h00, 1'b1, 15'h7FFF));
        send_tick(make_tick(1'b1, CHR_F, 1'b0, 15'h0000));
        drain();

        load_setting(plan[0]);
        send_empty(2);
        send_tick(make_tick(1'b1, CHR_B | CASE_SHIFT, 1'b0, 15'h0000));
        send_empty(2);
        send_tick(make_tick(1'b1, CHR_ZERO, 1'b0, 15'h0000));
        send_tick(make_tick(1'b1, CHR_COLON, 1'b0, 15'h0000));
        send_tick(make_tick(1'b1, CHR_ZERO - 8'd1, 1'b0, 15'h0000));
        send_tick(make_tick(1'b1, 8'hFF, 1'b0, 15'h0000));
        send_tick(make_tick(1'b1, CHR_LOW_Z, 1'b0, 15'h0000));
        // turn, then a second turn while the servo moves
        send_tick(make_tick(1'b1, CHR_L, 1'b0, 15'h0000));
        send_tick(make_tick(1'b1, CHR_R | CASE_SHIFT, 1'b0, 15'h0000));
        send_empty(3);
        // obstacle while turning: stop, then every forward-going command is refused
        send_tick(make_tick(1'b0, 8'h00, 1'b1, 15'd100));
        send_tick(make_tick(1'b1, CHR_F, 1'b0, 15'h0000));
        send_tick(make_tick(1'b1, CHR_R, 1'b0, 15'h0000));
        send_tick(make_tick(1'b1, CHR_L | CASE_SHIFT, 1'b0, 15'h0000));
        send_tick(make_tick(1'b0, 8'h00, 1'b1, 15'h0000));
        send_empty(4);
        send_tick(make_tick(1'b1, CHR_S | CASE_SHIFT, 1'b0, 15'h0000));

        for (int p = 0; p < RAND_SETTINGS; p++) begin
            drain();
            load_setting(plan[p]);
            repeat (RAND_TICKS) send_tick(rand_tick(plan[p].obst_cm));
        end

        // bring the sequencer back to idle with the obstacle cleared
        drain();
        load_setting(plan[6]);
        send_tick(make_tick(1'b1, CHR_S, 1'b1, 15'h0000));
        send_empty(3);
        send_tick(make_tick(1'b1, CHR_S, 1'b0, 15'h0000));
        send_empty(3);

        // largest timer values: the turn holds on the servo, no ramp slot comes up
        drain();
        load_setting(plan[7]);
        hold_fast = 1'b1;
        send_tick(make_tick(1'b1, CHR_L, 1'b0, 15'h0000));
        send_empty(LONG_TICKS);
        hold_fast = 1'b0;

        drain();
        repeat (4) @(posedge i_clk);
        $display("Sent %0d ticks under %0d register settings: commands in both cases,",
                 ticks_sent, settings_loaded);
        $display("turns, stops, obstacle latching, ramp limits and the largest timer settings.");
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/dss_pkg.sv
hdl/dss_req_if.sv
hdl/dss_res_if.sv
hdl/dss_cfg_regs.sv
hdl/dss_core.sv
hdl/drive_sequencer_soft_start_unit.sv
dv/dss_tick_checker.sv
dv/tb.sv
